### sv/sspu_pkg.sv
`timescale 1ns / 1ps

package sspu_pkg;

  // Default coordinate width; the unit works for 8 to 32 bits.
  localparam int unsigned COORD_BITS_DEF = 32;

  // Width of one configuration or input word, of a result point coordinate,
  // and of the register index.
  localparam int unsigned WW  = 32;
  localparam int unsigned PW  = 33;
  localparam int unsigned IDW = 3;

  typedef enum logic [1:0] {
    KIND_BOUNDARY = 2'd0,
    KIND_RAY      = 2'd1,
    KIND_SEGMENT  = 2'd2,
    KIND_RECT     = 2'd3
  } shape_kind_e;

  typedef enum logic {
    CMD_SUPPORT = 1'b0,
    CMD_CONTAIN = 1'b1
  } cmd_e;

  typedef enum logic [IDW-1:0] {
    REG_SHAPE_KIND     = 3'd0,
    REG_FIRST_X        = 3'd1,
    REG_FIRST_Y        = 3'd2,
    REG_SECOND_X       = 3'd3,
    REG_SECOND_Y       = 3'd4,
    REG_SCALAR_PARAM   = 3'd5,
    REG_FACE_THRESHOLD = 3'd6
  } reg_idx_e;

  // Rectangle answer for one word: support points and containment flag.
  typedef struct packed {
    logic [1:0]    count;
    logic [PW-1:0] p0x;
    logic [PW-1:0] p0y;
    logic [PW-1:0] p1x;
    logic [PW-1:0] p1y;
    logic          hit;
  } rect_res_t;

endpackage

### sv/sspu_rect.sv
`timescale 1ns / 1ps

module sspu_rect #(
  parameter int unsigned COORD_BITS = sspu_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] size_x_i,
  input  logic signed [COORD_BITS-1:0] size_y_i,
  input  logic signed [COORD_BITS-1:0] off_x_i,
  input  logic signed [COORD_BITS-1:0] off_y_i,
  input  logic signed [COORD_BITS-1:0] vec_x_i,
  input  logic signed [COORD_BITS-1:0] vec_y_i,
  input  logic [sspu_pkg::WW-1:0]      thr_i,
  output sspu_pkg::rect_res_t          res_o
);
  import sspu_pkg::*;

  localparam int unsigned IW = COORD_BITS + 2;
  localparam int unsigned EW = (IW > PW) ? IW : PW;
  localparam int unsigned AW = (COORD_BITS + 1 > WW) ? COORD_BITS + 1 : WW;

  function automatic logic [PW-1:0] to_pt(input logic signed [IW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    return e[PW-1:0];
  endfunction

  logic signed [IW-1:0] sx_w, sy_w, ox_w, oy_w, vx_w, vy_w;
  logic signed [IW-1:0] tx, ty, hx, hy, bx, by, ux, uy;
  logic signed [IW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [IW-1:0] face_v;
  logic [IW-1:0]        mag_x, mag_y;
  logic                 face_x, face_y;

  always_comb begin
    sx_w = IW'(size_x_i);
    sy_w = IW'(size_y_i);
    ox_w = IW'(off_x_i);
    oy_w = IW'(off_y_i);
    vx_w = IW'(vec_x_i);
    vy_w = IW'(vec_y_i);

    // Halving that truncates toward zero: bias negative values by one first.
    tx = sx_w + IW'(sx_w[IW-1]);
    ty = sy_w + IW'(sy_w[IW-1]);
    hx = tx >>> 1;
    hy = ty >>> 1;
    ux = sx_w + IW'(1);
    uy = sy_w + IW'(1);
    ux = ux + IW'(ux[IW-1]);
    uy = uy + IW'(uy[IW-1]);
    bx = ux >>> 1;
    by = uy >>> 1;

    lo_x = ox_w - hx;
    lo_y = oy_w - hy;
    hi_x = ox_w + bx;
    hi_y = oy_w + by;

    mag_x  = vx_w[IW-1] ? -vx_w : vx_w;
    mag_y  = vy_w[IW-1] ? -vy_w : vy_w;
    face_x = AW'(mag_x) > AW'(thr_i);
    face_y = AW'(mag_y) > AW'(thr_i);

    res_o     = '0;
    res_o.hit = (vx_w >= lo_x) && (vx_w < hi_x) && (vy_w >= lo_y) && (vy_w < hi_y);
    face_v    = '0;
    if (face_x) begin
      face_v      = (vx_w > 0) ? hi_x : lo_x;
      res_o.count = 2'd2;
      res_o.p0x   = to_pt(face_v);
      res_o.p0y   = to_pt(hi_y);
      res_o.p1x   = to_pt(face_v);
      res_o.p1y   = to_pt(lo_y);
    end else if (face_y) begin
      face_v      = (vy_w > 0) ? hi_y : lo_y;
      res_o.count = 2'd2;
      res_o.p0x   = to_pt(hi_x);
      res_o.p0y   = to_pt(face_v);
      res_o.p1x   = to_pt(lo_x);
      res_o.p1y   = to_pt(face_v);
    end else begin
      res_o.count = 2'd1;
      res_o.p0x   = to_pt(vx_w[IW-1] ? lo_x : hi_x);
      res_o.p0y   = to_pt(vy_w[IW-1] ? lo_y : hi_y);
    end
  end

endmodule

### sv/shape_support_point_unit_2d.sv
`timescale 1ns / 1ps

// Support-point and containment unit for one configured 2D integer shape.
// The shape (boundary, ray, segment or rectangle) and the face threshold are
// set through the write port cfg_we_i / cfg_idx_i / cfg_wdata_i, one register
// per cycle; the user must write them only while no word is in flight, and
// the block does not enforce this. Writes to index seven are ignored. Each
// input word on the valid/ready input channel is a support query (direction)
// or a containment query (point); each one yields exactly one result word on
// the valid/ready output channel, in order. From acceptance to out_valid_o a
// word passes an input register, a multiply stage with four COORD_BITS x
// (COORD_BITS+1) multipliers feeding the product register, and the add/compare
// stage feeding the result register. One word is accepted per cycle while the
// receiver does not stall. When it stalls, the result register holds its word
// and the stages behind it keep filling; in_ready_o drops only once all three
// stages hold a word. Reset empties the pipeline and clears every configuration
// register to zero, i.e. a world boundary with zero normal.
module shape_support_point_unit_2d #(
  parameter int unsigned COORD_BITS = sspu_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sspu_pkg::IDW-1:0]       cfg_idx_i,
  input  logic [sspu_pkg::WW-1:0]        cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic signed [sspu_pkg::WW-1:0] vec_x_i,
  input  logic signed [sspu_pkg::WW-1:0] vec_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     support_count_o,
  output logic signed [sspu_pkg::PW-1:0] point0_x_o,
  output logic signed [sspu_pkg::PW-1:0] point0_y_o,
  output logic signed [sspu_pkg::PW-1:0] point1_x_o,
  output logic signed [sspu_pkg::PW-1:0] point1_y_o,
  output logic                           inside_res_o
);
  import sspu_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned MW = 2 * CB + 1;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned CW = (SW > WW + 2) ? SW : WW + 2;

  function automatic logic [PW-1:0] to_pt(input logic signed [CB-1:0] v);
    return {{(PW - CB){v[CB-1]}}, v};
  endfunction

  // Configuration registers.
  shape_kind_e   shape_kind_q;
  logic [WW-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic [WW-1:0] scalar_param_q, face_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_kind_q     <= KIND_BOUNDARY;
      first_x_q        <= '0;
      first_y_q        <= '0;
      second_x_q       <= '0;
      second_y_q       <= '0;
      scalar_param_q   <= '0;
      face_threshold_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SHAPE_KIND:     shape_kind_q     <= shape_kind_e'(cfg_wdata_i[1:0]);
        REG_FIRST_X:        first_x_q        <= cfg_wdata_i;
        REG_FIRST_Y:        first_y_q        <= cfg_wdata_i;
        REG_SECOND_X:       second_x_q       <= cfg_wdata_i;
        REG_SECOND_Y:       second_y_q       <= cfg_wdata_i;
        REG_SCALAR_PARAM:   scalar_param_q   <= cfg_wdata_i;
        REG_FACE_THRESHOLD: face_threshold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Coordinates are the low COORD_BITS bits, taken as two's complement.
  logic signed [CB-1:0] fx, fy, sx, sy, sc;
  logic signed [CB:0]   dx, dy;
  assign fx = first_x_q[CB-1:0];
  assign fy = first_y_q[CB-1:0];
  assign sx = second_x_q[CB-1:0];
  assign sy = second_y_q[CB-1:0];
  assign sc = scalar_param_q[CB-1:0];
  assign dx = (CB + 1)'(sx) - (CB + 1)'(fx);
  assign dy = (CB + 1)'(sy) - (CB + 1)'(fy);

  // Pipeline flow: a stage takes a new word when it is empty or moving on.
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic adv_in, adv_mid, adv_out;
  assign adv_out    = !out_valid_q || out_ready_i;
  assign adv_mid    = !mid_valid_q || adv_out;
  assign adv_in     = !in_valid_q || adv_mid;
  assign in_ready_o = adv_in;

  // Input register.
  cmd_e                 cmd_q;
  logic signed [CB-1:0] vx_q, vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv_in) begin
      cmd_q <= cmd_e'(command_i);
      vx_q  <= vec_x_i[CB-1:0];
      vy_q  <= vec_y_i[CB-1:0];
    end
  end

  // Multiply stage. The first pair forms the plane dot for the boundary or
  // the direction dot along the segment; the second pair the cross term.
  logic signed [CB:0]   opa, opb;
  logic signed [MW-1:0] ma_d, mb_d, mc_d, md_d;
  rect_res_t            rect_d;

  assign opa  = (shape_kind_q == KIND_SEGMENT) ? dx : (CB + 1)'(fx);
  assign opb  = (shape_kind_q == KIND_SEGMENT) ? dy : (CB + 1)'(fy);
  assign ma_d = vx_q * opa;
  assign mb_d = vy_q * opb;
  assign mc_d = vx_q * dy;
  assign md_d = vy_q * dx;

  sspu_rect #(
    .COORD_BITS(COORD_BITS)
  ) u_rect (
    .size_x_i (fx),
    .size_y_i (fy),
    .off_x_i  (sx),
    .off_y_i  (sy),
    .vec_x_i  (vx_q),
    .vec_y_i  (vy_q),
    .thr_i    (face_threshold_q),
    .res_o    (rect_d)
  );

  cmd_e                 mid_cmd_q;
  logic                 mid_up_q;
  logic signed [MW-1:0] ma_q, mb_q, mc_q, md_q;
  rect_res_t            rect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (adv_mid) begin
      mid_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && adv_mid) begin
      mid_cmd_q <= cmd_q;
      mid_up_q  <= (vy_q > 0);
      ma_q      <= ma_d;
      mb_q      <= mb_d;
      mc_q      <= mc_d;
      md_q      <= md_d;
      rect_q    <= rect_d;
    end
  end

  // Add and compare stage, then selection by shape and command.
  logic signed [CW-1:0] dot, perp, sc_w, thr_w;
  logic                 seg_face, dot_pos, plane_in;
  logic [1:0]           count_d;
  logic [PW-1:0]        p0x_d, p0y_d, p1x_d, p1y_d;
  logic                 inside_d;

  always_comb begin
    dot      = CW'(ma_q) + CW'(mb_q);
    perp     = CW'(mc_q) - CW'(md_q);
    sc_w     = CW'(sc);
    thr_w    = CW'(face_threshold_q);
    plane_in = dot < sc_w;
    dot_pos  = dot > 0;
    seg_face = (perp > thr_w) || (perp < -thr_w);

    count_d  = 2'd0;
    p0x_d    = '0;
    p0y_d    = '0;
    p1x_d    = '0;
    p1y_d    = '0;
    inside_d = 1'b0;
    if (mid_cmd_q == CMD_CONTAIN) begin
      case (shape_kind_q)
        KIND_BOUNDARY: inside_d = plane_in;
        KIND_RECT:     inside_d = rect_q.hit;
        default:       inside_d = 1'b0;
      endcase
    end else begin
      case (shape_kind_q)
        KIND_RAY: begin
          count_d = 2'd1;
          p0y_d   = mid_up_q ? to_pt(sc) : '0;
        end
        KIND_SEGMENT: begin
          if (seg_face) begin
            count_d = 2'd2;
            p0x_d   = to_pt(fx);
            p0y_d   = to_pt(fy);
            p1x_d   = to_pt(sx);
            p1y_d   = to_pt(sy);
          end else begin
            count_d = 2'd1;
            p0x_d   = dot_pos ? to_pt(sx) : to_pt(fx);
            p0y_d   = dot_pos ? to_pt(sy) : to_pt(fy);
          end
        end
        KIND_RECT: begin
          count_d = rect_q.count;
          p0x_d   = rect_q.p0x;
          p0y_d   = rect_q.p0y;
          p1x_d   = rect_q.p1x;
          p1y_d   = rect_q.p1y;
        end
        default: count_d = 2'd0;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_valid_q && adv_out) begin
      support_count_o <= count_d;
      point0_x_o      <= p0x_d;
      point0_y_o      <= p0y_d;
      point1_x_o      <= p1x_d;
      point1_y_o      <= p1y_d;
      inside_res_o    <= inside_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The input side stalls only when every stage holds a word.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && mid_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline stage");

  // A support answer never carries a containment flag.
  a_inside_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && support_count_o != 2'd0) |-> !inside_res_o)
    else $error("containment flag set on a support answer");

  // Only faces of a segment or a rectangle give two points.
  a_two_points : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && support_count_o == 2'd2) |->
      (shape_kind_q == KIND_SEGMENT || shape_kind_q == KIND_RECT))
    else $error("two support points for a shape without faces");

  // A ray support point always lies on the y axis.
  a_ray_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shape_kind_q == KIND_RAY && support_count_o == 2'd1) |->
      (point0_x_o == '0))
    else $error("ray support point off the y axis");

endmodule
